### rtl/core/pts_pkg.sv
// Shared types and constants for the plucked tone synthesizer.
// Field widths, register indexes, reset values and output stage codes.
// No dependencies; imported by the top level.
package pts_pkg;

  // Default table size and phase resolution.
  localparam int TABLE_LEN_DEF       = 2048;
  localparam int PHASE_FRAC_BITS_DEF = 16;

  // Field widths.
  localparam int PHASE_STEP_W = 26;
  localparam int VOL_W        = 25;
  localparam int VOL_FRAC     = 24;
  localparam int ATTACK_W     = 16;
  localparam int GAP_W        = 18;
  localparam int COUNT_W      = 18;
  localparam int SAMPLE_W     = 16;
  localparam int STAGE_W      = 2;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 26;
  localparam int IN_DATA_W    = 8;
  localparam int OUT_DATA_W   = 24;

  localparam logic [VOL_W-1:0] VOL_MAX = {VOL_W{1'b1}};

  // Sample saturation limits.
  localparam logic [SAMPLE_W-1:0] SAMPLE_POS_MAX = 16'h7FFF;
  localparam logic [SAMPLE_W-1:0] SAMPLE_NEG_MIN = 16'h8000;

  // Fixed-point constants for building the cosine table.
  localparam longint unsigned PI_Q30  = 64'd3373259426;
  localparam longint unsigned ONE_Q30 = 64'd1073741824;
  localparam longint unsigned AMPL    = 64'd32767;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE           = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_VOLUME    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEP      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_STEP     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_SAMPLES = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_SAMPLES    = 3'd6;

  // Register reset values.
  localparam logic [PHASE_STEP_W-1:0] PHASE_STEP_RST     = 26'd1230356;
  localparam logic [VOL_W-1:0]        PEAK_VOLUME_RST    = 25'd6710886;
  localparam logic [VOL_W-1:0]        RAMP_STEP_RST      = 25'd167772;
  localparam logic [VOL_W-1:0]        DECAY_STEP_RST     = 25'd167772;
  localparam logic [ATTACK_W-1:0]     ATTACK_SAMPLES_RST = 16'd3360;
  localparam logic [GAP_W-1:0]        GAP_SAMPLES_RST    = 18'd0;

  // Stage codes reported with each sample.
  localparam logic [STAGE_W-1:0] STAGE_ATTACK  = 2'd0;
  localparam logic [STAGE_W-1:0] STAGE_DECAY   = 2'd1;
  localparam logic [STAGE_W-1:0] STAGE_SILENCE = 2'd2;
  localparam logic [STAGE_W-1:0] STAGE_CONT    = 2'd3;

  // Envelope state machine.
  typedef enum logic [2:0] {
    ENV_ATTACK  = 3'b001,
    ENV_DECAY   = 3'b010,
    ENV_SILENCE = 3'b100
  } env_state_t;

endpackage

### rtl/core/plucked_tone_synthesizer.sv
// Plucked tone synthesizer top level: phase accumulator, envelope, cosine
// ROM, volume multiplier and saturation in a four-stage pipeline.
// Depends on pts_pkg.
//
// Usage: every word accepted on the in_ channel is one sample tick and
// produces exactly one word on the out_ channel. in_tdata bit 0 is
// restart, which sends the envelope back to attack at zero volume before
// the tick is processed. out_tdata carries the signed 16-bit sample and
// the 2-bit stage code.
// An accepted word passes stage registers 1 to 3 and the output register
// before out_tvalid; one word is accepted every cycle while the receiver
// keeps out_tready high, as the envelope and phase update only depends on
// its own registers. When the receiver stalls, the whole pipeline holds
// and in_tready drops in the same cycle, so no word is lost.
// The cfg_ channel writes one register per word and is always ready; it
// is meant to be used while no ticks are in flight.
// Reset (synchronous, rst_n low) loads register defaults, clears the
// phase, volume and counter, puts the envelope at attack and empties the
// pipeline. The cosine table is a fixed ROM and needs no fill pass.
// TABLE_LEN must be a power of two.
module plucked_tone_synthesizer
  import pts_pkg::*;
#(
  parameter int TABLE_LEN       = TABLE_LEN_DEF,
  parameter int PHASE_FRAC_BITS = PHASE_FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // in_tdata: [0] restart, [7:1] zero
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // out_tdata: [15:0] sample (signed), [17:16] stage, [23:18] zero
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W   = $clog2(TABLE_LEN);
  localparam int PHASE_W = IDX_W + PHASE_FRAC_BITS;
  localparam int SUM_W   = ((PHASE_W > PHASE_STEP_W) ? PHASE_W : PHASE_STEP_W) + 1;
  localparam int ROM_SH  = $clog2(SAMPLE_W);
  localparam int PROD_W  = VOL_W + 1 + SAMPLE_W;
  localparam int MAG_W   = PROD_W - 1 - VOL_FRAC;

  // Cosine table, 32767 * cos(2*pi*i/TABLE_LEN) truncated toward zero,
  // built at elaboration from a Q30 Taylor series on the first quadrant.
  function automatic logic [TABLE_LEN*SAMPLE_W-1:0] build_rom();
    logic [TABLE_LEN*SAMPLE_W-1:0] rom;
    longint unsigned t, u, x, x2, term, mag;
    longint          acc;
    logic            neg;
    logic [SAMPLE_W-1:0] val;
    int              i, k;
    rom = '0;
    for (i = 0; i < TABLE_LEN; i++) begin
      t = longint'(i);
      if (2 * t > longint'(TABLE_LEN)) t = longint'(TABLE_LEN) - t;
      u   = 2 * t;
      neg = 1'b0;
      if (2 * u > longint'(TABLE_LEN)) begin
        neg = 1'b1;
        u   = longint'(TABLE_LEN) - u;
      end
      x    = (PI_Q30 * u) >> IDX_W;
      x2   = (x * x) >> 30;
      acc  = longint'(ONE_Q30);
      term = ONE_Q30;
      for (k = 1; k <= 10; k++) begin
        // Divide by (2k-1)*(2k) for term k of the series.
        term = (term * x2) >> 30;
        case (k)
          1:       term = term / 64'd2;
          2:       term = term / 64'd12;
          3:       term = term / 64'd30;
          4:       term = term / 64'd56;
          5:       term = term / 64'd90;
          6:       term = term / 64'd132;
          7:       term = term / 64'd182;
          8:       term = term / 64'd240;
          9:       term = term / 64'd306;
          default: term = term / 64'd380;
        endcase
        if (k % 2 == 1) acc = acc - longint'(term);
        else            acc = acc + longint'(term);
      end
      if (acc < 0) acc = 0;
      if (acc > longint'(ONE_Q30)) acc = longint'(ONE_Q30);
      mag = (AMPL * longint'(acc)) >> 30;
      val = mag[SAMPLE_W-1:0];
      if (neg) val = -val;
      rom[i*SAMPLE_W +: SAMPLE_W] = val;
    end
    return rom;
  endfunction

  localparam logic [TABLE_LEN*SAMPLE_W-1:0] COS_ROM = build_rom();

  // Configuration registers.
  logic [PHASE_STEP_W-1:0] phase_step_r;
  logic                    mode_r;
  logic [VOL_W-1:0]        peak_volume_r;
  logic [VOL_W-1:0]        ramp_step_r;
  logic [VOL_W-1:0]        decay_step_r;
  logic [ATTACK_W-1:0]     attack_samples_r;
  logic [GAP_W-1:0]        gap_samples_r;

  // Synthesis state.
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [VOL_W-1:0]   vol_r, vol_nxt;
  env_state_t         env_r, env_nxt;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;

  // Pipeline.
  logic                       en;
  logic                       in_acc;
  logic                       v1_r, v2_r, v3_r, out_tvalid_r;
  logic [IDX_W-1:0]           idx1_r;
  logic [VOL_W-1:0]           vol1_r, vol2_r;
  logic [STAGE_W-1:0]         st1_r, st2_r, st3_r, stage_r;
  logic signed [SAMPLE_W-1:0] rom2_r;
  logic signed [PROD_W-1:0]   prod3_r, prod_nxt;
  logic [SAMPLE_W-1:0]        sample_r, sample_nxt;

  // Tick decode.
  logic [VOL_W-1:0]   use_vol;
  logic [STAGE_W-1:0] use_st;
  logic               restart;
  env_state_t         cur_env;
  logic [VOL_W-1:0]   cur_vol;
  logic [COUNT_W-1:0] cur_cnt;
  logic [COUNT_W:0]   cnt_inc;
  logic [VOL_W:0]     ramp_sum;
  logic [VOL_W-1:0]   decayed;
  logic               advance;
  logic [SUM_W-1:0]   phase_sum;

  assign en        = !out_tvalid_r || out_tready;
  assign in_tready = en;
  assign in_acc    = in_tvalid && en;
  assign cfg_ready = 1'b1;
  assign restart   = in_tdata[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r     <= PHASE_STEP_RST;
      mode_r           <= 1'b0;
      peak_volume_r    <= PEAK_VOLUME_RST;
      ramp_step_r      <= RAMP_STEP_RST;
      decay_step_r     <= DECAY_STEP_RST;
      attack_samples_r <= ATTACK_SAMPLES_RST;
      gap_samples_r    <= GAP_SAMPLES_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PHASE_STEP:     phase_step_r     <= cfg_data[PHASE_STEP_W-1:0];
        CFG_MODE:           mode_r           <= cfg_data[0];
        CFG_PEAK_VOLUME:    peak_volume_r    <= cfg_data[VOL_W-1:0];
        CFG_RAMP_STEP:      ramp_step_r      <= cfg_data[VOL_W-1:0];
        CFG_DECAY_STEP:     decay_step_r     <= cfg_data[VOL_W-1:0];
        CFG_ATTACK_SAMPLES: attack_samples_r <= cfg_data[ATTACK_W-1:0];
        CFG_GAP_SAMPLES:    gap_samples_r    <= cfg_data[GAP_W-1:0];
        default: ;
      endcase
    end
  end

  // Envelope and phase update for one tick.
  always_comb begin
    cur_env  = restart ? ENV_ATTACK : env_r;
    cur_vol  = restart ? '0 : vol_r;
    cur_cnt  = restart ? '0 : cnt_r;
    cnt_inc  = {1'b0, cur_cnt} + 1'b1;
    ramp_sum = {1'b0, cur_vol} + {1'b0, ramp_step_r};
    decayed  = (cur_vol > decay_step_r) ? cur_vol - decay_step_r : '0;
    env_nxt  = cur_env;
    vol_nxt  = cur_vol;
    cnt_nxt  = cur_cnt;
    use_vol  = cur_vol;
    use_st   = STAGE_CONT;
    advance  = 1'b1;
    if (!mode_r) begin
      use_vol = peak_volume_r;
    end else begin
      unique case (cur_env)
        ENV_ATTACK: begin
          if (cur_vol < peak_volume_r) begin
            vol_nxt = ramp_sum[VOL_W] ? VOL_MAX : ramp_sum[VOL_W-1:0];
          end
          use_vol = vol_nxt;
          use_st  = STAGE_ATTACK;
          if (cnt_inc >= {{(COUNT_W + 1 - ATTACK_W){1'b0}}, attack_samples_r}) begin
            env_nxt = ENV_DECAY;
            cnt_nxt = '0;
          end else begin
            cnt_nxt = cnt_inc[COUNT_W-1:0];
          end
        end
        ENV_DECAY: begin
          use_st  = STAGE_DECAY;
          vol_nxt = decayed;
          if (decayed == '0) begin
            cnt_nxt = '0;
            env_nxt = (gap_samples_r == '0) ? ENV_ATTACK : ENV_SILENCE;
          end
        end
        default: begin
          // Silence: muted, phase held; a zero volume gives a zero sample.
          use_vol = '0;
          use_st  = STAGE_SILENCE;
          advance = 1'b0;
          if (cnt_inc >= {{(COUNT_W + 1 - GAP_W){1'b0}}, gap_samples_r}) begin
            env_nxt = ENV_ATTACK;
            vol_nxt = '0;
            cnt_nxt = '0;
          end else begin
            cnt_nxt = cnt_inc[COUNT_W-1:0];
          end
        end
      endcase
    end
    // The table length is a power of two, so the wrap is a truncation.
    phase_sum = SUM_W'(phase_r) + SUM_W'(phase_step_r);
    phase_nxt = advance ? phase_sum[PHASE_W-1:0] : phase_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      vol_r   <= '0;
      env_r   <= ENV_ATTACK;
      cnt_r   <= '0;
    end else if (in_acc) begin
      phase_r <= phase_nxt;
      vol_r   <= vol_nxt;
      env_r   <= env_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Volume times table entry; truncation toward zero, then saturation.
  logic                       prod_neg;
  logic [PROD_W-1:0]          prod_abs;
  logic [MAG_W-1:0]           mag;

  assign prod_nxt = $signed({1'b0, vol2_r}) * rom2_r;

  always_comb begin
    prod_neg = prod3_r[PROD_W-1];
    prod_abs = prod_neg ? PROD_W'(-prod3_r) : PROD_W'(prod3_r);
    mag      = prod_abs[PROD_W-2:VOL_FRAC];
    if (prod_neg) begin
      sample_nxt = (mag > {1'b0, SAMPLE_NEG_MIN}) ? SAMPLE_NEG_MIN : -mag[SAMPLE_W-1:0];
    end else begin
      sample_nxt = (mag > {1'b0, SAMPLE_POS_MAX}) ? SAMPLE_POS_MAX : mag[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      v3_r         <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      v1_r         <= in_tvalid;
      v2_r         <= v1_r;
      v3_r         <= v2_r;
      out_tvalid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idx1_r   <= phase_r[PHASE_W-1:PHASE_FRAC_BITS];
      vol1_r   <= use_vol;
      st1_r    <= use_st;
      rom2_r   <= COS_ROM[{idx1_r, {ROM_SH{1'b0}}} +: SAMPLE_W];
      vol2_r   <= vol1_r;
      st2_r    <= st1_r;
      prod3_r  <= prod_nxt;
      st3_r    <= st2_r;
      sample_r <= sample_nxt;
      stage_r  <= st3_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(OUT_DATA_W - SAMPLE_W - STAGE_W){1'b0}}, stage_r, sample_r};

  // A silent tick carries zero volume into the multiplier.
  a_silence_mute: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && st1_r == STAGE_SILENCE |-> vol1_r == '0)
    else $error("silent tick entered the pipeline with nonzero volume");

  // A silent tick leaves the block as a zero sample.
  a_silence_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && stage_r == STAGE_SILENCE |-> sample_r == '0)
    else $error("silent stage produced a nonzero sample");

  // A word in the third stage reaches the output register when the pipe moves.
  a_pipe_flow: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && en |=> out_tvalid_r)
    else $error("pipeline dropped a word");

  // A restart in pluck mode leaves the counter at its first attack tick.
  a_restart_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && restart && mode_r |=> cnt_r <= COUNT_W'(1))
    else $error("restart did not clear the stage counter");

endmodule
